/* hw/rtl/ltmc_pkg.sv */
// ltmc_pkg: shared types, register map and constants of the line tracker mode controller
// no dependencies
`default_nettype none

package ltmc_pkg;

  localparam int NUM_SENSORS  = 7;
  localparam int ADC_BITS_DEF = 10;

  // register indexes on the configuration port
  localparam logic [2:0] REG_LOST_THR   = 3'd0;
  localparam logic [2:0] REG_INTER_THR  = 3'd1;
  localparam logic [2:0] REG_REGAIN_THR = 3'd2;
  localparam logic [2:0] REG_LOST_NEED  = 3'd3;
  localparam logic [2:0] REG_REGAIN_NEED = 3'd4;
  localparam logic [2:0] REG_MAX_WALL   = 3'd5;
  localparam logic [2:0] REG_TGT_WALL   = 3'd6;
  localparam logic [2:0] REG_CIRCLE_MIN = 3'd7;

  // tracking modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_CIRCLE = 2'd1;
  localparam logic [1:0] MODE_WALL   = 2'd2;

  // drive actions
  localparam logic [2:0] ACT_CAL        = 3'd0;
  localparam logic [2:0] ACT_STEER      = 3'd1;
  localparam logic [2:0] ACT_HOLD       = 3'd2;
  localparam logic [2:0] ACT_CIRCLE_IN  = 3'd3;
  localparam logic [2:0] ACT_CIRCLE_OUT = 3'd4;
  localparam logic [2:0] ACT_WALL       = 3'd5;

  localparam logic [6:0] SCALE_FULL = 7'd100;
  localparam logic [9:0] POS_LIMIT  = 10'd700;
  localparam logic [7:0] COUNT_SAT  = 8'd255;

  typedef struct packed {
    logic [9:0]  lost_thr;
    logic [6:0]  inter_thr;
    logic [8:0]  regain_thr;
    logic [7:0]  lost_need;
    logic [7:0]  regain_need;
    logic [15:0] max_wall;
    logic [15:0] tgt_wall;
    logic [15:0] circle_min;
  } ltmc_cfg_t;

  // sensor weights, scaled by ten, leftmost first
  function automatic logic signed [7:0] sensor_weight(input logic [2:0] idx);
    logic signed [7:0] w;
    case (idx)
      3'd0: w = 8'sd36;
      3'd1: w = 8'sd20;
      3'd2: w = 8'sd10;
      3'd4: w = -8'sd10;
      3'd5: w = -8'sd20;
      3'd6: w = -8'sd36;
      default: w = 8'sd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ltmc_if.sv */
// ltmc_if: valid/ready channel interfaces for sensor frames and tracker results
// depends on ltmc_pkg
`default_nettype none

interface ltmc_in_if #(parameter int ADC_BITS = ltmc_pkg::ADC_BITS_DEF);
  logic                valid;
  logic                ready;
  logic                operation;
  logic [ADC_BITS-1:0] sample_0;
  logic [ADC_BITS-1:0] sample_1;
  logic [ADC_BITS-1:0] sample_2;
  logic [ADC_BITS-1:0] sample_3;
  logic [ADC_BITS-1:0] sample_4;
  logic [ADC_BITS-1:0] sample_5;
  logic [ADC_BITS-1:0] sample_6;
  logic [15:0]         wall_distance;
  logic [31:0]         now_ms;

  modport source (output valid, operation, sample_0, sample_1, sample_2, sample_3,
                  sample_4, sample_5, sample_6, wall_distance, now_ms, input ready);
  modport sink (input valid, operation, sample_0, sample_1, sample_2, sample_3,
                sample_4, sample_5, sample_6, wall_distance, now_ms, output ready);
endinterface

interface ltmc_out_if;
  logic               valid;
  logic               ready;
  logic signed [10:0] position;
  logic [1:0]         mode;
  logic [2:0]         drive_action;
  logic signed [16:0] wall_error;

  modport source (output valid, position, mode, drive_action, wall_error, input ready);
  modport sink (input valid, position, mode, drive_action, wall_error, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ltmc_regs.sv */
// ltmc_regs: apb-style configuration registers of the tracker
// depends on ltmc_pkg
`default_nettype none

module ltmc_regs (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output ltmc_pkg::ltmc_cfg_t     cfg
);
  import ltmc_pkg::*;

  ltmc_cfg_t cfg_r;
  logic      wr_en;

  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lost_thr    <= 10'd50;
      cfg_r.inter_thr   <= 7'd60;
      cfg_r.regain_thr  <= 9'd150;
      cfg_r.lost_need   <= 8'd5;
      cfg_r.regain_need <= 8'd3;
      cfg_r.max_wall    <= 16'd400;
      cfg_r.tgt_wall    <= 16'd100;
      cfg_r.circle_min  <= 16'd1000;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_LOST_THR:    cfg_r.lost_thr    <= pwdata[9:0];
        REG_INTER_THR:   cfg_r.inter_thr   <= pwdata[6:0];
        REG_REGAIN_THR:  cfg_r.regain_thr  <= pwdata[8:0];
        REG_LOST_NEED:   cfg_r.lost_need   <= pwdata[7:0];
        REG_REGAIN_NEED: cfg_r.regain_need <= pwdata[7:0];
        REG_MAX_WALL:    cfg_r.max_wall    <= pwdata[15:0];
        REG_TGT_WALL:    cfg_r.tgt_wall    <= pwdata[15:0];
        REG_CIRCLE_MIN:  cfg_r.circle_min  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_LOST_THR:    prdata = {22'd0, cfg_r.lost_thr};
      REG_INTER_THR:   prdata = {25'd0, cfg_r.inter_thr};
      REG_REGAIN_THR:  prdata = {23'd0, cfg_r.regain_thr};
      REG_LOST_NEED:   prdata = {24'd0, cfg_r.lost_need};
      REG_REGAIN_NEED: prdata = {24'd0, cfg_r.regain_need};
      REG_MAX_WALL:    prdata = {16'd0, cfg_r.max_wall};
      REG_TGT_WALL:    prdata = {16'd0, cfg_r.tgt_wall};
      REG_CIRCLE_MIN:  prdata = {16'd0, cfg_r.circle_min};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/ltmc_divider.sv */
// ltmc_divider: shared restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
`default_nettype none

module ltmc_divider #(
  parameter int NW = 17,
  parameter int DW = 10
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quot
);
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic          fits;

  assign trial = {rem_r, quo_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quot  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= DW'(trial - {1'b0, den_r});
        quo_r <= {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= trial[DW-1:0];
        quo_r <= {quo_r[NW-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/line_tracker_mode_controller.sv */
// line_tracker_mode_controller: top level, sequencer around one shared divider
// depends on ltmc_pkg, ltmc_if, ltmc_regs, ltmc_divider
//
//   port     | dir    | what moves
//   in_ch    | sink   | sensor frame: operation, seven samples, wall distance, time
//   out_ch   | source | result: position, mode, drive action, wall error
//   cfg_*    | slave  | apb-style register writes and reads, no wait states
//
// a calibration frame goes from idle to the emit state, then into the output register once it is free
// a tracking frame takes 8 divisions of NW quotient bits each (NW = max(ADC_BITS+7, 17)),
// all run in turn on the one bit-serial divider
// in_ch.ready is high only while the sequencer is idle; a finished result waits in
// the output register while the next frame is taken
// reset is synchronous, active low; calibration spans reset to full-scale min, zero max
`default_nettype none

module line_tracker_mode_controller #(
  parameter int ADC_BITS = ltmc_pkg::ADC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  ltmc_in_if.sink          in_ch,
  ltmc_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import ltmc_pkg::*;

  localparam int NW = (ADC_BITS + 7 > 17) ? ADC_BITS + 7 : 17;
  localparam int DW = (ADC_BITS > 10) ? ADC_BITS : 10;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SC_GO  = 3'd1;
  localparam logic [2:0] ST_SC_WT  = 3'd2;
  localparam logic [2:0] ST_PS_GO  = 3'd3;
  localparam logic [2:0] ST_PS_WT  = 3'd4;
  localparam logic [2:0] ST_DECIDE = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  ltmc_cfg_t cfg;

  ltmc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );
  assign cfg_pready = 1'b1;

  logic [2:0]          state_r;
  logic [2:0]          k_r;
  logic [ADC_BITS-1:0] raw_r     [NUM_SENSORS];
  logic [ADC_BITS-1:0] cal_min_r [NUM_SENSORS];
  logic [ADC_BITS-1:0] cal_max_r [NUM_SENSORS];
  logic [ADC_BITS-1:0] in_raw    [NUM_SENSORS];
  logic [15:0]         dist_r;
  logic [31:0]         now_r;
  logic                scale_ok_r;
  logic [9:0]          total_r;
  logic signed [15:0]  wsum_r;
  logic [8:0]          csum_r;

  logic signed [10:0]  last_pos_r, last_pos_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic [7:0]          lost_r, lost_nxt;
  logic [7:0]          regain_r, regain_nxt;
  logic [31:0]         cstart_r, cstart_nxt;

  logic signed [10:0]  res_pos_r, res_pos_nxt;
  logic [2:0]          res_act_r, res_act_nxt;
  logic signed [16:0]  res_werr_r, res_werr_nxt;
  logic signed [10:0]  steer_pos_r;

  logic                out_valid_r;
  logic signed [10:0]  out_pos_r;
  logic [1:0]          out_mode_r;
  logic [2:0]          out_act_r;
  logic signed [16:0]  out_werr_r;

  logic                accept;
  logic                div_start;
  logic [NW-1:0]       div_num;
  logic [DW-1:0]       div_den;
  logic                div_done;
  logic [NW-1:0]       div_quot;

  assign in_raw[0] = in_ch.sample_0;
  assign in_raw[1] = in_ch.sample_1;
  assign in_raw[2] = in_ch.sample_2;
  assign in_raw[3] = in_ch.sample_3;
  assign in_raw[4] = in_ch.sample_4;
  assign in_raw[5] = in_ch.sample_5;
  assign in_raw[6] = in_ch.sample_6;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // operand selection for the shared divider
  logic [ADC_BITS-1:0] cur_raw, cur_lo, cur_hi;
  logic [ADC_BITS-1:0] raw_off, span;
  logic [15:0]         wsum_abs;
  logic                scale_ok;

  assign cur_raw  = raw_r[k_r];
  assign cur_lo   = cal_min_r[k_r];
  assign cur_hi   = cal_max_r[k_r];
  assign raw_off  = cur_raw - cur_lo;
  assign span     = cur_hi - cur_lo;
  assign scale_ok = (cur_hi > cur_lo) && (cur_raw > cur_lo);
  assign wsum_abs = wsum_r[15] ? 16'(-wsum_r) : 16'(wsum_r);

  always_comb begin
    if (state_r == ST_PS_GO) begin
      div_num = NW'(wsum_abs) * NW'(10);
      div_den = DW'(total_r);
    end else begin
      div_num = NW'(raw_off) * NW'(SCALE_FULL);
      div_den = DW'(span);
    end
  end
  assign div_start = (state_r == ST_SC_GO) || (state_r == ST_PS_GO);

  ltmc_divider #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // scaled sample from the divider, clamped to full scale
  logic [6:0]         s_val;
  logic signed [7:0]  s_w;
  logic signed [15:0] s_prod;

  always_comb begin
    if (!scale_ok_r)
      s_val = 7'd0;
    else if (div_quot > NW'(SCALE_FULL))
      s_val = SCALE_FULL;
    else
      s_val = div_quot[6:0];
  end
  assign s_w    = sensor_weight(k_r);
  assign s_prod = $signed({9'd0, s_val}) * $signed({{8{s_w[7]}}, s_w});

  // signed, clamped position from the final (position) division
  logic [9:0]         pos_mag;
  logic signed [10:0] pos_div;

  assign pos_mag = (div_quot > NW'(POS_LIMIT)) ? POS_LIMIT : div_quot[9:0];
  assign pos_div = wsum_r[15] ? -$signed({1'b0, pos_mag}) : $signed({1'b0, pos_mag});

  // mode decision
  logic [7:0]  lost_inc, regain_inc;
  logic [8:0]  inter_lim;
  logic        inter, lost, regain_hit;
  logic [31:0] in_circle;
  logic [15:0] dist_sat;

  assign lost_inc   = (lost_r == COUNT_SAT) ? COUNT_SAT : lost_r + 8'd1;
  assign regain_inc = (regain_r == COUNT_SAT) ? COUNT_SAT : regain_r + 8'd1;
  // csum/3 > thr is csum > 3*thr+2
  assign inter_lim  = {1'b0, cfg.inter_thr, 1'b0} + {2'b0, cfg.inter_thr} + 9'd2;
  assign inter      = csum_r > inter_lim;
  assign lost       = total_r < cfg.lost_thr;
  assign regain_hit = csum_r > cfg.regain_thr;
  assign in_circle  = now_r - cstart_r;
  assign dist_sat   = (dist_r > cfg.max_wall) ? cfg.max_wall : dist_r;

  always_comb begin
    last_pos_nxt = last_pos_r;
    mode_nxt     = mode_r;
    lost_nxt     = lost_r;
    regain_nxt   = regain_r;
    cstart_nxt   = cstart_r;
    res_pos_nxt  = 11'sd0;
    res_act_nxt  = ACT_STEER;
    res_werr_nxt = 17'sd0;
    if (mode_r != MODE_WALL && lost) begin
      lost_nxt    = lost_inc;
      res_pos_nxt = last_pos_r;
      res_act_nxt = ACT_HOLD;
      if (lost_inc >= cfg.lost_need && dist_r < cfg.max_wall) begin
        mode_nxt = MODE_WALL;
        lost_nxt = 8'd0;
      end
    end else begin
      if (mode_r != MODE_WALL)
        lost_nxt = 8'd0;
      if (mode_r == MODE_NORMAL && inter) begin
        mode_nxt    = MODE_CIRCLE;
        cstart_nxt  = now_r;
        res_act_nxt = ACT_CIRCLE_IN;
      end else if (mode_r == MODE_CIRCLE && inter &&
                   in_circle >= {16'd0, cfg.circle_min}) begin
        mode_nxt    = MODE_NORMAL;
        res_act_nxt = ACT_CIRCLE_OUT;
      end else if (mode_r == MODE_WALL) begin
        if (regain_hit && regain_inc >= cfg.regain_need) begin
          mode_nxt   = MODE_NORMAL;
          regain_nxt = 8'd0;
        end else begin
          regain_nxt   = regain_hit ? regain_inc : 8'd0;
          res_act_nxt  = ACT_WALL;
          res_werr_nxt = $signed({1'b0, dist_sat}) - $signed({1'b0, cfg.tgt_wall});
        end
      end else begin
        // plain steering; an empty frame keeps the last position
        res_pos_nxt  = (total_r != 10'd0) ? steer_pos_r : last_pos_r;
        last_pos_nxt = res_pos_nxt;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      k_r     <= 3'd0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            k_r     <= 3'd0;
            state_r <= in_ch.operation ? ST_SC_GO : ST_EMIT;
          end
        end
        ST_SC_GO: state_r <= ST_SC_WT;
        ST_SC_WT: begin
          if (div_done) begin
            if (k_r == 3'(NUM_SENSORS - 1)) begin
              state_r <= ST_PS_GO;
            end else begin
              k_r     <= k_r + 3'd1;
              state_r <= ST_SC_GO;
            end
          end
        end
        ST_PS_GO: state_r <= ST_PS_WT;
        ST_PS_WT: if (div_done) state_r <= ST_DECIDE;
        ST_DECIDE: state_r <= ST_EMIT;
        ST_EMIT: if (!out_valid_r || out_ch.ready) state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // frame capture and accumulation
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NUM_SENSORS; i++)
        raw_r[i] <= in_raw[i];
      dist_r <= in_ch.wall_distance;
      now_r  <= in_ch.now_ms;
    end
    if (accept) begin
      total_r <= 10'd0;
      wsum_r  <= 16'sd0;
      csum_r  <= 9'd0;
    end else if (state_r == ST_SC_WT && div_done) begin
      total_r <= total_r + 10'(s_val);
      wsum_r  <= wsum_r + s_prod;
      if (k_r == 3'd2 || k_r == 3'd3 || k_r == 3'd4)
        csum_r <= csum_r + 9'(s_val);
    end
    if (state_r == ST_SC_GO)
      scale_ok_r <= scale_ok;
    if (state_r == ST_PS_WT && div_done)
      steer_pos_r <= pos_div;
    if (state_r == ST_IDLE) begin
      res_pos_r  <= 11'sd0;
      res_act_r  <= ACT_CAL;
      res_werr_r <= 17'sd0;
    end else if (state_r == ST_DECIDE) begin
      res_pos_r  <= res_pos_nxt;
      res_act_r  <= res_act_nxt;
      res_werr_r <= res_werr_nxt;
    end
  end

  // calibration spans and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        cal_min_r[i] <= '1;
        cal_max_r[i] <= '0;
      end
      last_pos_r <= 11'sd0;
      mode_r     <= MODE_NORMAL;
      lost_r     <= 8'd0;
      regain_r   <= 8'd0;
      cstart_r   <= 32'd0;
    end else begin
      if (accept && !in_ch.operation) begin
        for (int i = 0; i < NUM_SENSORS; i++) begin
          if (in_raw[i] > cal_max_r[i]) cal_max_r[i] <= in_raw[i];
          if (in_raw[i] < cal_min_r[i]) cal_min_r[i] <= in_raw[i];
        end
      end
      if (state_r == ST_DECIDE) begin
        last_pos_r <= last_pos_nxt;
        mode_r     <= mode_nxt;
        lost_r     <= lost_nxt;
        regain_r   <= regain_nxt;
        cstart_r   <= cstart_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_EMIT && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT && (!out_valid_r || out_ch.ready)) begin
      out_pos_r  <= res_pos_r;
      out_mode_r <= mode_r;
      out_act_r  <= res_act_r;
      out_werr_r <= res_werr_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.position     = out_pos_r;
  assign out_ch.mode         = out_mode_r;
  assign out_ch.drive_action = out_act_r;
  assign out_ch.wall_error   = out_werr_r;

endmodule

`default_nettype wire
